[hw/rtl/m4vt_pkg.sv]
// Shared types and codes for the 4x4 fixed-point vertex transform.
// No dependencies; imported by every module of the block.
package m4vt_pkg;

	localparam int DATA_W          = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	// item kinds
	localparam logic [2:0] KIND_WR_MAT    = 3'd0;
	localparam logic [2:0] KIND_WR_OPD    = 3'd1;
	localparam logic [2:0] KIND_COMPOSE   = 3'd2;
	localparam logic [2:0] KIND_XFORM_PT  = 3'd3;
	localparam logic [2:0] KIND_XFORM_VEC = 3'd4;

	typedef logic signed [DATA_W-1:0] word_t;

	// one queued word: a point arrives here with its w already forced to one
	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] idx;
		word_t      value;
		word_t      vx;
		word_t      vy;
		word_t      vz;
		word_t      vw;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[hw/rtl/m4vt_queue.sv]
// Short FIFO of decoded items between front and back end.
// Depends on m4vt_pkg.
module m4vt_queue
	import m4vt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   pop_item,
	output q_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[hw/rtl/m4vt_front.sv]
// Front end: takes words on the start/busy port, drops unused kinds and
// turns a point into a vec4 with w of one. Depends on m4vt_pkg.
module m4vt_front
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       start,
	input  logic [2:0] kind,
	input  logic [3:0] elem_index,
	input  word_t      elem_value,
	input  word_t      vec_x,
	input  word_t      vec_y,
	input  word_t      vec_z,
	input  word_t      vec_w,
	input  q_stat_t    q_stat,
	output logic       busy,
	output logic       push,
	output item_t      push_item
);

	localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

	logic known;

	always_comb begin
		unique case (kind) inside
			KIND_WR_MAT, KIND_WR_OPD, KIND_COMPOSE,
			KIND_XFORM_PT, KIND_XFORM_VEC: known = 1'b1;
			default:                       known = 1'b0;
		endcase
	end

	assign busy = q_stat.full;
	assign push = start && !q_stat.full && known;

	always_comb begin
		push_item.kind  = kind;
		push_item.idx   = elem_index;
		push_item.value = elem_value;
		push_item.vx    = vec_x;
		push_item.vy    = vec_y;
		push_item.vz    = vec_z;
		// column 3 then passes through unscaled: (t * one) >> frac == t
		push_item.vw    = (kind == KIND_XFORM_PT) ? word_t'(ONE) : vec_w;
	end

endmodule

[hw/rtl/m4vt_back.sv]
// Back end: matrix stores, one shared 32x32 multiplier and accumulator,
// sequencing element writes, compose and transforms. Depends on m4vt_pkg.
module m4vt_back
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  q_stat_t q_stat,
	input  item_t   q_item,
	output logic    pop,
	output word_t   out_x,
	output word_t   out_y,
	output word_t   out_z,
	output word_t   out_w,
	output logic    saturated,
	output logic    done
);

	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = PROD_W - FRAC_BITS + 2;
	localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
	localparam logic [5:0] CNT_XFORM_LAST   = 6'd15;
	localparam logic [5:0] CNT_COMPOSE_LAST = 6'd63;
	localparam logic signed [ACC_W-1:0] SUM_MAX = {{(ACC_W-DATA_W){1'b0}}, 1'b0,
		{(DATA_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SUM_MIN = {{(ACC_W-DATA_W){1'b1}}, 1'b1,
		{(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic       comp;
		logic       point;
		logic       fin;
		logic [1:0] r;
		logic [1:0] c;
	} ctl_t;

	word_t tmat_q [16];
	word_t omat_q [16];
	item_t cur_q;
	logic  running_q;
	logic [5:0] cnt_q;

	logic       comp_i;
	logic [1:0] r_i;
	logic [1:0] c_i;
	logic [1:0] e_i;
	logic [5:0] cnt_last;
	word_t      a_op;
	word_t      b_op;
	logic signed [PROD_W-1:0] prod;

	ctl_t ctl_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] shifted;
	logic signed [ACC_W-1:0] sum;
	word_t clamped;
	logic  sat_now;
	logic  elem_done;
	logic  row_wr;
	word_t rowbuf_q [3];
	word_t res_q [3];
	logic  sat_q;
	word_t row_val [4];

	word_t out_x_q;
	word_t out_y_q;
	word_t out_z_q;
	word_t out_w_q;
	logic  sat_out_q;
	logic  done_q;

	// ---- issue: one product per cycle
	assign pop      = !running_q && !ctl_s1.valid && !q_stat.empty;
	assign comp_i   = (cur_q.kind == KIND_COMPOSE);
	assign r_i      = comp_i ? cnt_q[5:4] : cnt_q[3:2];
	assign c_i      = cnt_q[3:2];
	assign e_i      = cnt_q[1:0];
	assign cnt_last = comp_i ? CNT_COMPOSE_LAST : CNT_XFORM_LAST;
	assign a_op     = tmat_q[{e_i, r_i}];

	always_comb begin
		if (comp_i) begin
			b_op = omat_q[{c_i, e_i}];
		end else begin
			case (e_i)
				2'd0:    b_op = cur_q.vx;
				2'd1:    b_op = cur_q.vy;
				2'd2:    b_op = cur_q.vz;
				default: b_op = cur_q.vw;
			endcase
		end
	end

	assign prod = a_op * b_op;

	// ---- accumulate: floor shift, add, clamp
	assign shifted = ACC_W'(prod_s1 >>> FRAC_BITS);
	assign sum     = (ctl_s1.first ? '0 : acc_q) + shifted;

	always_comb begin
		sat_now = 1'b0;
		clamped = word_t'(sum[DATA_W-1:0]);
		if (sum > SUM_MAX) begin
			clamped = word_t'(SUM_MAX[DATA_W-1:0]);
			sat_now = 1'b1;
		end else if (sum < SUM_MIN) begin
			clamped = word_t'(SUM_MIN[DATA_W-1:0]);
			sat_now = 1'b1;
		end
	end

	assign elem_done = ctl_s1.valid && ctl_s1.last;
	// compose writes a whole row once its four elements are known; later rows
	// never read it again
	assign row_wr    = elem_done && ctl_s1.comp && (ctl_s1.c == 2'd3);

	always_comb begin
		row_val[0] = rowbuf_q[0];
		row_val[1] = rowbuf_q[1];
		row_val[2] = rowbuf_q[2];
		row_val[3] = clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q     <= '0;
			ctl_s1    <= '0;
			done_q    <= 1'b0;
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					tmat_q[4'(r + c * 4)] <= (r == c) ? word_t'(ONE) : '0;
					omat_q[4'(r + c * 4)] <= '0;
				end
			end
		end else begin
			ctl_s1.valid <= running_q;
			ctl_s1.first <= (e_i == 2'd0);
			ctl_s1.last  <= (e_i == 2'd3);
			ctl_s1.comp  <= comp_i;
			ctl_s1.point <= (cur_q.kind == KIND_XFORM_PT);
			ctl_s1.fin   <= (cnt_q == cnt_last);
			ctl_s1.r     <= r_i;
			ctl_s1.c     <= c_i;
			done_q       <= elem_done && ctl_s1.fin && !ctl_s1.comp;

			if (pop) begin
				unique case (q_item.kind) inside
					KIND_WR_MAT:   tmat_q[q_item.idx] <= q_item.value;
					KIND_WR_OPD:   omat_q[q_item.idx] <= q_item.value;
					KIND_COMPOSE, KIND_XFORM_PT, KIND_XFORM_VEC: begin
						running_q <= 1'b1;
						cnt_q     <= '0;
					end
					default: ;
				endcase
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cnt_last) begin
					running_q <= 1'b0;
				end
			end

			if (row_wr) begin
				for (int c = 0; c < 4; c++) begin
					tmat_q[{2'(c), ctl_s1.r}] <= row_val[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
		end
		prod_s1 <= prod;
		if (ctl_s1.valid) begin
			acc_q <= sum;
		end
		if (elem_done && ctl_s1.comp && ctl_s1.c != 2'd3) begin
			rowbuf_q[ctl_s1.c] <= clamped;
		end
		if (elem_done && !ctl_s1.comp) begin
			if (ctl_s1.r != 2'd3) begin
				res_q[ctl_s1.r] <= clamped;
			end
			sat_q <= ((ctl_s1.r == 2'd0) ? 1'b0 : sat_q) | sat_now;
		end
		if (elem_done && ctl_s1.fin && !ctl_s1.comp) begin
			out_x_q   <= res_q[0];
			out_y_q   <= res_q[1];
			out_z_q   <= res_q[2];
			// point: w row is neither reported nor flagged
			out_w_q   <= ctl_s1.point ? '0 : clamped;
			sat_out_q <= sat_q | (!ctl_s1.point && sat_now);
		end
	end

	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign out_w     = out_w_q;
	assign saturated = sat_out_q;
	assign done      = done_q;

endmodule

[hw/rtl/matrix4_vertex_transform_top.sv]
// 4x4 fixed-point matrix store with point/vec4 transform and compose.
// Top level; depends on m4vt_pkg, m4vt_front, m4vt_queue, m4vt_back.
//
// Words are taken when start is high and busy is low; busy rises only when
// the two-deep queue is full. An element write is loaded from the queue by
// the back end, and writes follow each other at one per cycle while no
// transform or compose is running. A point or vec4 transform is first loaded
// from the queue. It then uses the one shared 32x32 multiplier for four rows
// of four products, and the multiplier pipeline drains before the next item
// is loaded. A compose runs in the same way, with 64 products. A transform's
// last product passes the product register and then the result registers
// before its result appears. The result is marked by done, high for exactly
// one cycle; out_x/out_y/out_z/out_w/saturated hold it until the next
// result. The receiver cannot stall it, so it must take
// every word as it comes. Kinds five to seven are swallowed without effect.
module matrix4_vertex_transform_top
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic [3:0]         elem_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w,
	output logic               saturated
);

	q_stat_t q_stat;
	item_t   push_item;
	item_t   pop_item;
	logic    push;
	logic    pop;

	m4vt_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.start      (start),
		.kind       (kind),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.vec_w      (vec_w),
		.q_stat     (q_stat),
		.busy       (busy),
		.push       (push),
		.push_item  (push_item)
	);

	m4vt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	m4vt_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_item    (pop_item),
		.pop       (pop),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_w     (out_w),
		.saturated (saturated),
		.done      (done)
	);

endmodule

[sim/m4vt_checker.sv]
// Checker for the 4x4 fixed-point vertex transform: mirrors both matrices,
// predicts every transformed vertex and compares it with the returned word.
// Depends on m4vt_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module m4vt_checker
	import m4vt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [2:0]         kind,
	input  logic [3:0]         elem_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	input  logic signed [31:0] vec_w,
	input  logic               done,
	input  logic signed [31:0] out_x,
	input  logic signed [31:0] out_y,
	input  logic signed [31:0] out_z,
	input  logic signed [31:0] out_w,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending
);

	localparam longint WORD_MAX = 64'sd2147483647;
	localparam longint WORD_MIN = -64'sd2147483648;

	typedef struct {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
		logic  sat;
	} vertex_t;

	word_t   xform_mat [16];
	word_t   opd_mat [16];
	vertex_t expected_vertices [$];
	vertex_t want;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(string name, word_t got, word_t exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %h expected %h", name, got, exp_val));
	endtask

	// exact product, then arithmetic shift: rounds toward minus infinity
	function automatic longint fx_product(word_t a, word_t b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return prod >>> FRAC_BITS;
	endfunction

	function automatic word_t clamp_sum(input longint s, inout bit clamped);
		if (s > WORD_MAX) begin
			clamped = 1'b1;
			return word_t'(WORD_MAX);
		end
		if (s < WORD_MIN) begin
			clamped = 1'b1;
			return word_t'(WORD_MIN);
		end
		return word_t'(s);
	endfunction

	function automatic void compose_update();
		word_t  nm [16];
		longint acc;
		bit     ignored;
		ignored = 1'b0;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 0;
				for (int e = 0; e < 4; e++)
					acc += fx_product(xform_mat[r + e * 4], opd_mat[e + c * 4]);
				nm[r + c * 4] = clamp_sum(acc, ignored);
			end
		xform_mat = nm;
	endfunction

	function automatic vertex_t transform_vertex(logic [2:0] k, word_t vx, word_t vy,
			word_t vz, word_t vw);
		longint  acc;
		word_t   vin [3];
		word_t   comp [4];
		bit      clamped;
		vertex_t res;
		clamped = 1'b0;
		vin = '{vx, vy, vz};
		for (int r = 0; r < 4; r++) begin
			acc = 0;
			for (int c = 0; c < 3; c++)
				acc += fx_product(xform_mat[r + c * 4], vin[c]);
			// a point has w of one: the translation column goes in unscaled
			if (k == KIND_XFORM_PT)
				acc += longint'(xform_mat[r + 12]);
			else
				acc += fx_product(xform_mat[r + 12], vw);
			// point w row is dropped, so it never raises the flag
			if (r < 3 || k == KIND_XFORM_VEC)
				comp[r] = clamp_sum(acc, clamped);
			else
				comp[r] = '0;
		end
		res.x   = comp[0];
		res.y   = comp[1];
		res.z   = comp[2];
		res.w   = comp[3];
		res.sat = clamped;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				xform_mat[i] = (i % 5 == 0) ? word_t'(1 << FRAC_BITS) : '0;
				opd_mat[i]   = '0;
			end
			expected_vertices.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (expected_vertices.size() == 0) begin
					report_mismatch($sformatf("result word with none pending: %h %h %h %h %b",
						out_x, out_y, out_z, out_w, saturated));
				end else begin
					want = expected_vertices.pop_front();
					check_field("out_x", out_x, want.x);
					check_field("out_y", out_y, want.y);
					check_field("out_z", out_z, want.z);
					check_field("out_w", out_w, want.w);
					check_field("saturated", word_t'(saturated), word_t'(want.sat));
				end
			end
			if (start && !busy) begin
				case (kind)
					KIND_WR_MAT:    xform_mat[elem_index] = elem_value;
					KIND_WR_OPD:    opd_mat[elem_index] = elem_value;
					KIND_COMPOSE:   compose_update();
					KIND_XFORM_PT,
					KIND_XFORM_VEC: expected_vertices.push_back(
						transform_vertex(kind, vec_x, vec_y, vec_z, vec_w));
					default: ;
				endcase
			end
			pending = expected_vertices.size();
		end
	end

endmodule

[sim/tb_matrix4_vertex_transform_top.sv]
// Testbench top for the 4x4 fixed-point vertex transform: drives directed
// and random words, gives the verdict. Depends on m4vt_pkg, m4vt_checker
// and the block under test.
`timescale 1ns / 100ps

module tb_matrix4_vertex_transform_top;
	import m4vt_pkg::*;

	localparam int         ITEM_TARGET      = 1050;
	localparam int         TAIL_CYCLES      = 200;
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_LAST         = 3'd7;
	localparam word_t      Q_ONE            = word_t'(1 << FRAC_BITS_DEF);
	localparam word_t      W_MAX            = 32'sh7FFF_FFFF;
	localparam word_t      W_MIN            = 32'sh8000_0000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         kind;
	logic [3:0]         elem_index;
	logic signed [31:0] elem_value;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] vec_w;
	logic               done;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic               saturated;

	int fail_count;
	int pending;
	int words_sent;
	bit idle_mode;

	matrix4_vertex_transform_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.vec_w      (vec_w),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.saturated  (saturated)
	);

	m4vt_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.kind       (kind),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.vec_x      (vec_x),
		.vec_y      (vec_y),
		.vec_z      (vec_z),
		.vec_w      (vec_w),
		.done       (done),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.out_w      (out_w),
		.saturated  (saturated),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// mostly modest Q16.16 values; wild mode leans to full range and extremes
	function automatic word_t q_value(bit wild);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (wild)
			r = r / 2 + 50;
		if (r < 70)
			return word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'h0004_0000);
		if (r < 82)
			return word_t'($urandom_range(0, 32'h0200_0000)) - word_t'(32'h0100_0000);
		if (r < 94)
			return word_t'($urandom);
		case ($urandom_range(0, 6))
			0:       return W_MAX;
			1:       return W_MIN;
			2:       return '0;
			3:       return Q_ONE;
			4:       return -Q_ONE;
			5:       return word_t'(1);
			default: return word_t'(-1);
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_word(logic [2:0] k, logic [3:0] idx, word_t val,
			word_t vx, word_t vy, word_t vz, word_t vw);
		int gap;
		gap = idle_mode ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      = 1'b1;
		kind       = k;
		elem_index = idx;
		elem_value = val;
		vec_x      = vx;
		vec_y      = vy;
		vec_z      = vz;
		vec_w      = vw;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (k <= KIND_XFORM_VEC)
			words_sent++;
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_vertex(logic [2:0] k, word_t vx, word_t vy, word_t vz, word_t vw);
		send_word(k, 4'($urandom), word_t'($urandom), vx, vy, vz, vw);
	endtask

	task automatic send_elem(logic [2:0] k, logic [3:0] idx, word_t val);
		send_word(k, idx, val, word_t'($urandom), word_t'($urandom),
			word_t'($urandom), word_t'($urandom));
	endtask

	task automatic run_directed();
		idle_mode = 1'b0;
		send_vertex(KIND_XFORM_PT, W_MAX, W_MIN, Q_ONE, W_MIN);
		send_vertex(KIND_XFORM_VEC, W_MAX, W_MIN, word_t'(-1), W_MIN);
		for (int k = KIND_UNUSED_FIRST; k <= KIND_LAST; k++)
			send_elem(3'(k), 4'($urandom), word_t'($urandom));
		// translation at full scale clamps x
		send_elem(KIND_WR_MAT, 4'd12, W_MAX);
		send_vertex(KIND_XFORM_PT, W_MAX, '0, '0, '0);
		send_vertex(KIND_XFORM_VEC, Q_ONE, '0, '0, Q_ONE);
		// huge w row: ignored for a point, clamps for a vec4
		send_elem(KIND_WR_MAT, 4'd12, '0);
		send_elem(KIND_WR_MAT, 4'd3, W_MAX);
		send_elem(KIND_WR_MAT, 4'd15, W_MIN);
		send_vertex(KIND_XFORM_PT, W_MAX, '0, '0, W_MAX);
		send_vertex(KIND_XFORM_VEC, W_MAX, '0, '0, Q_ONE);
		// tiny negative product floors to -1
		send_elem(KIND_WR_MAT, 4'd0, word_t'(-1));
		send_vertex(KIND_XFORM_PT, word_t'(1), word_t'(-1), word_t'(1), '0);
		drain_results();
		// compose with elements that clamp on their own
		send_elem(KIND_WR_OPD, 4'd0, W_MAX);
		send_elem(KIND_WR_OPD, 4'd15, W_MIN);
		send_elem(KIND_WR_OPD, 4'd5, Q_ONE);
		send_elem(KIND_WR_OPD, 4'd10, -Q_ONE);
		send_elem(KIND_COMPOSE, 4'($urandom), word_t'($urandom));
		send_vertex(KIND_XFORM_VEC, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
	endtask

	task automatic load_matrix(logic [2:0] k, bit wild);
		for (int i = 0; i < 16; i++)
			send_elem(k, 4'(i), q_value(wild));
	endtask

	task automatic run_random();
		int scene;
		int n;
		bit wild;
		while (words_sent < ITEM_TARGET) begin
			idle_mode = ($urandom_range(0, 3) != 0);
			wild      = ($urandom_range(0, 4) == 0);
			scene     = $urandom_range(0, 99);
			if (scene < 20) begin
				load_matrix(KIND_WR_MAT, wild);
			end else if (scene < 35) begin
				load_matrix(KIND_WR_OPD, wild);
				send_elem(KIND_COMPOSE, 4'($urandom), word_t'($urandom));
			end else if (scene < 85) begin
				if ($urandom_range(0, 9) == 0)
					drain_results();
				n = $urandom_range(3, 30);
				repeat (n)
					send_vertex($urandom_range(0, 1) ? KIND_XFORM_PT : KIND_XFORM_VEC,
						q_value(wild), q_value(wild), q_value(wild), q_value(wild));
			end else begin
				// stray words of any kind, fully random fields
				n = $urandom_range(1, 6);
				repeat (n)
					send_word(3'($urandom_range(KIND_WR_MAT, KIND_LAST)), 4'($urandom),
						word_t'($urandom), word_t'($urandom), word_t'($urandom),
						word_t'($urandom), word_t'($urandom));
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = KIND_WR_MAT;
		elem_index = '0;
		elem_value = '0;
		vec_x      = '0;
		vec_y      = '0;
		vec_z      = '0;
		vec_w      = '0;
		words_sent = 0;
		idle_mode  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
hw/rtl/m4vt_pkg.sv
hw/rtl/m4vt_queue.sv
hw/rtl/m4vt_front.sv
hw/rtl/m4vt_back.sv
hw/rtl/matrix4_vertex_transform_top.sv
sim/m4vt_checker.sv
sim/tb_matrix4_vertex_transform_top.sv
